// ----- sv/lsrc_pkg.sv -----
`timescale 1ns / 1ps

package lsrc_pkg;

    // Command opcodes.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_OFF      = 3'd1;
    localparam logic [2:0] OP_RAINBOW  = 3'd2;
    localparam logic [2:0] OP_BRIGHTER = 3'd3;
    localparam logic [2:0] OP_DIMMER   = 3'd4;
    localparam logic [2:0] OP_PRESET   = 3'd5;
    localparam logic [2:0] OP_SET      = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_DELAY = 2'd0;
    localparam logic [1:0] CFG_COLOR_STEP = 2'd1;
    localparam logic [1:0] CFG_BRIGHT_STEP = 2'd2;

    localparam int PRESET_COUNT = 20;
    localparam int JOB_DEPTH = 2;

    // Reset values of the state and configuration registers.
    localparam logic [15:0] TICKS_RESET = 16'd1;
    localparam logic [7:0] LEVEL_RESET = 8'd255;
    localparam logic [15:0] STEP_DELAY_RESET = 16'd100;
    localparam logic [6:0] COLOR_STEP_RESET = 7'd20;
    localparam logic [7:0] BRIGHT_STEP_RESET = 8'd10;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] preset_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pixel_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] level;
        logic       last_pixel;
    } pix_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // One frame to be emitted: the color of pixel 0, whether the colors walk
    // between groups, the wheel step of that walk and the brightness.
    typedef struct packed {
        rgb_t       color;
        logic       walk;
        logic [6:0] step;
        logic [7:0] level;
    } job_t;

    typedef struct packed {
        logic [15:0] step_delay;
        logic [6:0]  color_step;
        logic [7:0]  bright_step;
    } cfg_t;

    typedef logic signed [10:0] comp_t;

    typedef struct packed {
        comp_t r;
        comp_t g;
        comp_t b;
    } wide_t;

    // Preset color table.
    function automatic rgb_t preset_color(input logic [4:0] idx);
        logic [23:0] c;
        begin
            unique case (idx)
                5'd0:    c = 24'hFFFFFF;
                5'd1:    c = 24'hFF0000;
                5'd2:    c = 24'h00FF00;
                5'd3:    c = 24'h0000FF;
                5'd4:    c = 24'hFF0F00;
                5'd5:    c = 24'h05FF05;
                5'd6:    c = 24'h0A0AFF;
                5'd7:    c = 24'hFF1464;
                5'd8:    c = 24'hFF1600;
                5'd9:    c = 24'h5959FF;
                5'd10:   c = 24'hB300FF;
                5'd11:   c = 24'hFF3277;
                5'd12:   c = 24'hFF2600;
                5'd13:   c = 24'h004F00;
                5'd14:   c = 24'hB300CF;
                5'd15:   c = 24'h4949FF;
                5'd16:   c = 24'hFF6600;
                5'd17:   c = 24'h001F00;
                5'd18:   c = 24'hE600FF;
                5'd19:   c = 24'h6969FF;
                default: c = 24'h000000;
            endcase
            preset_color = c;
        end
    endfunction

    // One move around the color wheel in signed arithmetic, clamped above.
    function automatic wide_t wheel_move(input rgb_t c, input logic [6:0] st);
        comp_t r;
        comp_t g;
        comp_t b;
        comp_t s;
        wide_t w;
        begin
            r = comp_t'({3'b000, c.r});
            g = comp_t'({3'b000, c.g});
            b = comp_t'({3'b000, c.b});
            s = comp_t'({4'b0000, st});
            if (g < 11'sd255 && b == 11'sd0)
            begin
                r = r - s;
                g = g + s;
            end
            if (b < 11'sd255 && r == 11'sd0)
            begin
                g = g - s;
                b = b + s;
            end
            if (r < 11'sd255 && g == 11'sd0)
            begin
                r = r + s;
                b = b - s;
            end
            if (r > 11'sd255) r = 11'sd255;
            if (g > 11'sd255) g = 11'sd255;
            if (b > 11'sd255) b = 11'sd255;
            w.r = r;
            w.g = g;
            w.b = b;
            wheel_move = w;
        end
    endfunction

    // The step from the old pixel 0 color to the new one: clamped to 0..255.
    function automatic rgb_t first_step(input rgb_t c, input logic [6:0] st);
        wide_t w;
        rgb_t o;
        begin
            w = wheel_move(c, st);
            o.r = (w.r < 11'sd0) ? 8'd0 : w.r[7:0];
            o.g = (w.g < 11'sd0) ? 8'd0 : w.g[7:0];
            o.b = (w.b < 11'sd0) ? 8'd0 : w.b[7:0];
            first_step = o;
        end
    endfunction

    // The step between pixel groups: components below the step drop to zero.
    function automatic rgb_t group_step(input rgb_t c, input logic [6:0] st);
        wide_t w;
        comp_t s;
        rgb_t o;
        begin
            w = wheel_move(c, st);
            s = comp_t'({4'b0000, st});
            o.r = (w.r < s) ? 8'd0 : w.r[7:0];
            o.g = (w.g < s) ? 8'd0 : w.g[7:0];
            o.b = (w.b < s) ? 8'd0 : w.b[7:0];
            group_step = o;
        end
    endfunction

endpackage

// ----- sv/lsrc_front.sv -----
`timescale 1ns / 1ps

module lsrc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             cmd_accept,
    input  lsrc_pkg::cmd_t   cmd,
    output logic             job_valid,
    output lsrc_pkg::job_t   job
);
    import lsrc_pkg::*;

    cfg_t        cfg_reg;
    rgb_t        base_reg;
    rgb_t        base_next;
    logic        walk_reg;
    logic        walk_next;
    logic [6:0]  wstep_reg;
    logic [6:0]  wstep_next;
    logic [7:0]  level_reg;
    logic [7:0]  level_next;
    logic        rainbow_reg;
    logic        rainbow_next;
    logic [15:0] ticks_reg;
    logic [15:0] ticks_next;
    logic [15:0] ticks_dec;
    logic        emit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay  <= STEP_DELAY_RESET;
            cfg_reg.color_step  <= COLOR_STEP_RESET;
            cfg_reg.bright_step <= BRIGHT_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_DELAY:  cfg_reg.step_delay  <= cfg_data;
                CFG_COLOR_STEP:  cfg_reg.color_step  <= cfg_data[6:0];
                CFG_BRIGHT_STEP: cfg_reg.bright_step <= cfg_data[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign ticks_dec = (ticks_reg == 16'd0) ? 16'd0 : ticks_reg - 16'd1;

    // Command decode: next strip state and whether a frame follows.
    always_comb
    begin
        base_next    = base_reg;
        walk_next    = walk_reg;
        wstep_next   = wstep_reg;
        level_next   = level_reg;
        rainbow_next = rainbow_reg;
        ticks_next   = ticks_reg;
        emit         = 1'b0;
        unique case (cmd.opcode)
            OP_TICK:
            begin
                if (rainbow_reg && ticks_dec == 16'd0)
                begin
                    ticks_next = cfg_reg.step_delay;
                    base_next  = first_step(base_reg, cfg_reg.color_step);
                    walk_next  = 1'b1;
                    wstep_next = cfg_reg.color_step;
                    emit       = 1'b1;
                end
                else
                begin
                    ticks_next = ticks_dec;
                end
            end
            OP_OFF:
            begin
                base_next    = '0;
                walk_next    = 1'b0;
                rainbow_next = 1'b0;
                emit         = 1'b1;
            end
            OP_RAINBOW:
            begin
                rainbow_next = 1'b1;
            end
            OP_BRIGHTER:
            begin
                level_next   = level_reg + cfg_reg.bright_step;
                rainbow_next = 1'b0;
                emit         = 1'b1;
            end
            OP_DIMMER:
            begin
                level_next   = level_reg - cfg_reg.bright_step;
                rainbow_next = 1'b0;
                emit         = 1'b1;
            end
            OP_PRESET:
            begin
                if (cmd.preset_index < 5'(PRESET_COUNT))
                begin
                    base_next    = preset_color(cmd.preset_index);
                    walk_next    = 1'b0;
                    rainbow_next = 1'b0;
                    emit         = 1'b1;
                end
            end
            OP_SET:
            begin
                base_next.r = cmd.red_in;
                base_next.g = cmd.green_in;
                base_next.b = cmd.blue_in;
                walk_next   = 1'b0;
                emit        = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Strip state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            walk_reg    <= 1'b0;
            wstep_reg   <= COLOR_STEP_RESET;
            level_reg   <= LEVEL_RESET;
            rainbow_reg <= 1'b0;
            ticks_reg   <= TICKS_RESET;
        end
        else if (cmd_accept)
        begin
            base_reg    <= base_next;
            walk_reg    <= walk_next;
            wstep_reg   <= wstep_next;
            level_reg   <= level_next;
            rainbow_reg <= rainbow_next;
            ticks_reg   <= ticks_next;
        end
    end

    // Frame job handed to the queue in the cycle the command is taken.
    assign job_valid  = cmd_accept & emit;
    assign job.color  = base_next;
    assign job.walk   = walk_next;
    assign job.step   = wstep_next;
    assign job.level  = level_next;

endmodule

// ----- sv/lsrc_queue.sv -----
`timescale 1ns / 1ps

module lsrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  lsrc_pkg::job_t   wr_job,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_valid,
    output lsrc_pkg::job_t   rd_job
);
    import lsrc_pkg::*;

    localparam int AW = $clog2(JOB_DEPTH);

    job_t          mem [JOB_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    assign full     = (count_reg == (AW+1)'(JOB_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];

endmodule

// ----- sv/lsrc_back.sv -----
`timescale 1ns / 1ps

module lsrc_back #(
    parameter int PIXEL_COUNT = 15,
    parameter int GROUP_SPAN  = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  lsrc_pkg::job_t   job,
    output logic             job_take,
    output lsrc_pkg::pix_t   pixel,
    output logic             empty,
    input  logic             pop
);
    import lsrc_pkg::*;

    localparam int PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int GW = (GROUP_SPAN > 1) ? $clog2(GROUP_SPAN) : 1;

    logic          busy_reg;
    logic [PW-1:0] pix_reg;
    logic [GW-1:0] grp_reg;
    rgb_t          color_reg;
    logic          walk_reg;
    logic [6:0]    step_reg;
    logic [7:0]    level_reg;
    logic          out_valid_reg;
    pix_t          out_reg;
    logic          advance;
    logic          is_last;
    logic          group_end;
    pix_t          cur_pix;

    assign advance   = busy_reg && (!out_valid_reg || pop);
    assign job_take  = !busy_reg && job_valid;
    assign is_last   = (pix_reg == PW'(PIXEL_COUNT - 1));
    assign group_end = (grp_reg == GW'(GROUP_SPAN - 1));

    // Word for the current pixel.
    always_comb
    begin
        cur_pix.pixel_index = 4'(pix_reg);
        cur_pix.red_out     = color_reg.r;
        cur_pix.green_out   = color_reg.g;
        cur_pix.blue_out    = color_reg.b;
        cur_pix.level       = level_reg;
        cur_pix.last_pixel  = is_last;
    end

    // Pixel sequencer: one pixel per cycle unless the output stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pix_reg  <= '0;
            grp_reg  <= '0;
        end
        else if (job_take)
        begin
            busy_reg <= 1'b1;
            pix_reg  <= '0;
            grp_reg  <= '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            pix_reg <= pix_reg + PW'(1);
            grp_reg <= group_end ? '0 : grp_reg + GW'(1);
        end
    end

    // Payload held for the frame; a walking color steps after each group.
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            color_reg <= job.color;
            walk_reg  <= job.walk;
            step_reg  <= job.step;
            level_reg <= job.level;
        end
        else if (advance && walk_reg && group_end)
        begin
            color_reg <= group_step(color_reg, step_reg);
        end
    end

    // Output register that holds a word until it is popped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= cur_pix;
        end
    end

    assign pixel = out_reg;
    assign empty = !out_valid_reg;

endmodule

// ----- sv/led_strip_rainbow_controller_core.sv -----
// A command is taken while push is high and the queue is not full. With the back end idle,
// a frame job goes through the job queue and the back-end pixel sequencer into the output
// register. A frame leaves as PIXEL_COUNT words, one per cycle while the output word is
// popped; a new frame starts only after the last word of the previous one left the sequencer.
// Reset is asynchronous, active low: strip black, brightness 255, rainbow mode off,
// countdown 1, configuration registers at their defaults, job queue and output word empty.
`timescale 1ns / 1ps

module led_strip_rainbow_controller_core #(
    parameter int PIXEL_COUNT = 15,
    parameter int GROUP_SPAN  = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  lsrc_pkg::cmd_t   cmd,
    output logic             empty,
    input  logic             pop,
    output lsrc_pkg::pix_t   pixel,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import lsrc_pkg::*;

    logic cmd_accept;
    logic q_wr;
    job_t q_wr_job;
    logic q_rd;
    logic q_valid;
    job_t q_rd_job;

    assign cfg_ready  = 1'b1;
    assign cmd_accept = push && !full;

    // Command front end: owns the strip state and issues frame jobs.
    lsrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_accept (cmd_accept),
        .cmd        (cmd),
        .job_valid  (q_wr),
        .job        (q_wr_job)
    );

    // Short job queue between front and back.
    lsrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_job   (q_wr_job),
        .full     (full),
        .rd_en    (q_rd),
        .rd_valid (q_valid),
        .rd_job   (q_rd_job)
    );

    // Pixel back end: turns each job into a frame of words.
    lsrc_back #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .GROUP_SPAN  (GROUP_SPAN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_rd_job),
        .job_take  (q_rd),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ----- tb/sv/led_strip_rainbow_controller_core_tb.sv -----
`timescale 1ns / 1ps

module led_strip_rainbow_controller_core_tb;
    import lsrc_pkg::*;

    localparam int PIXELS = 15;
    localparam int SPAN = 2;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int MAX_REPORTS = 10;
    // The one opcode that the block leaves unused.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Shadow copy of the strip state; it works out the pixel words that each
    // accepted command should produce and checks the words that come out.
    class strip_shadow;
        rgb_t        store [PIXELS];
        logic [7:0]  level;
        bit          rainbow;
        logic [15:0] ticks_left;
        logic [15:0] step_delay;
        logic [6:0]  color_step;
        logic [7:0]  bright_step;
        pix_t        pending_pixels [$];
        int          mismatches;

        function new();
            foreach (store[i])
                store[i] = '0;
            level = LEVEL_RESET;
            rainbow = 1'b0;
            ticks_left = TICKS_RESET;
            step_delay = STEP_DELAY_RESET;
            color_step = COLOR_STEP_RESET;
            bright_step = BRIGHT_STEP_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_STEP_DELAY:  step_delay = data;
                CFG_COLOR_STEP:  color_step = data[6:0];
                CFG_BRIGHT_STEP: bright_step = data[7:0];
                default: ;
            endcase
        endfunction

        function rgb_t preset_rgb(logic [4:0] idx);
            logic [23:0] c;
            case (idx)
                5'd0:    c = 24'hFFFFFF;
                5'd1:    c = 24'hFF0000;
                5'd2:    c = 24'h00FF00;
                5'd3:    c = 24'h0000FF;
                5'd4:    c = 24'hFF0F00;
                5'd5:    c = 24'h05FF05;
                5'd6:    c = 24'h0A0AFF;
                5'd7:    c = 24'hFF1464;
                5'd8:    c = 24'hFF1600;
                5'd9:    c = 24'h5959FF;
                5'd10:   c = 24'hB300FF;
                5'd11:   c = 24'hFF3277;
                5'd12:   c = 24'hFF2600;
                5'd13:   c = 24'h004F00;
                5'd14:   c = 24'hB300CF;
                5'd15:   c = 24'h4949FF;
                5'd16:   c = 24'hFF6600;
                5'd17:   c = 24'h001F00;
                5'd18:   c = 24'hE600FF;
                5'd19:   c = 24'h6969FF;
                default: c = 24'h000000;
            endcase
            return c;
        endfunction

        function void fill(rgb_t c);
            foreach (store[i])
                store[i] = c;
        endfunction

        // One move around the color wheel on signed components, capped at 255.
        function void wheel(inout int r, inout int g, inout int b, input int st);
            if (g < 255 && b == 0)
            begin
                r -= st;
                g += st;
            end
            if (b < 255 && r == 0)
            begin
                g -= st;
                b += st;
            end
            if (r < 255 && g == 0)
            begin
                r += st;
                b -= st;
            end
            if (r > 255) r = 255;
            if (g > 255) g = 255;
            if (b > 255) b = 255;
        endfunction

        // Step pixel 0 once, then paint the groups while the color walks on.
        function void rainbow_step();
            int st;
            int r;
            int g;
            int b;
            st = int'(color_step);
            r = int'(store[0].r);
            g = int'(store[0].g);
            b = int'(store[0].b);
            wheel(r, g, b, st);
            if (r < 0) r = 0;
            if (g < 0) g = 0;
            if (b < 0) b = 0;
            for (int i = 0; i < PIXELS; i += SPAN)
            begin
                for (int j = i; j < i + SPAN && j < PIXELS; j++)
                    store[j] = {r[7:0], g[7:0], b[7:0]};
                wheel(r, g, b, st);
                if (r < st) r = 0;
                if (g < st) g = 0;
                if (b < st) b = 0;
            end
        endfunction

        function void show_frame();
            pix_t p;
            for (int i = 0; i < PIXELS; i++)
            begin
                p.pixel_index = i[3:0];
                p.red_out = store[i].r;
                p.green_out = store[i].g;
                p.blue_out = store[i].b;
                p.level = level;
                p.last_pixel = (i == PIXELS - 1);
                pending_pixels.push_back(p);
            end
        endfunction

        function void take_command(cmd_t c);
            case (c.opcode)
                OP_TICK:
                begin
                    if (ticks_left != 16'd0)
                        ticks_left--;
                    if (rainbow && ticks_left == 16'd0)
                    begin
                        ticks_left = step_delay;
                        rainbow_step();
                        show_frame();
                    end
                end
                OP_OFF:
                begin
                    fill('0);
                    rainbow = 1'b0;
                    show_frame();
                end
                OP_RAINBOW:
                    rainbow = 1'b1;
                OP_BRIGHTER:
                begin
                    level = level + bright_step;
                    rainbow = 1'b0;
                    show_frame();
                end
                OP_DIMMER:
                begin
                    level = level - bright_step;
                    rainbow = 1'b0;
                    show_frame();
                end
                OP_PRESET:
                begin
                    // An index past the table is dropped without a trace.
                    if (c.preset_index < PRESET_COUNT)
                    begin
                        fill(preset_rgb(c.preset_index));
                        rainbow = 1'b0;
                        show_frame();
                    end
                end
                OP_SET:
                begin
                    fill({c.red_in, c.green_in, c.blue_in});
                    show_frame();
                end
                default: ;
            endcase
        endfunction

        function string fmt(pix_t p);
            return $sformatf("idx=%0d rgb=%h_%h_%h level=%0d last=%0b", p.pixel_index,
                             p.red_out, p.green_out, p.blue_out, p.level, p.last_pixel);
        endfunction

        function void check_pixel(pix_t got);
            pix_t  want;
            string bad;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: pixel word with nothing expected: %s", $time, fmt(got));
                return;
            end
            want = pending_pixels.pop_front();
            bad = "";
            if (got.pixel_index !== want.pixel_index) bad = {bad, " pixel_index"};
            if (got.red_out !== want.red_out) bad = {bad, " red_out"};
            if (got.green_out !== want.green_out) bad = {bad, " green_out"};
            if (got.blue_out !== want.blue_out) bad = {bad, " blue_out"};
            if (got.level !== want.level) bad = {bad, " level"};
            if (got.last_pixel !== want.last_pixel) bad = {bad, " last_pixel"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: pixel word mismatch in%s: expected %s, actual %s",
                             $time, bad, fmt(want), fmt(got));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    cmd_t        cmd = '0;
    logic        empty;
    logic        pop = 1'b0;
    pix_t        pixel;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    logic        holding = 1'b0;
    event        start_hold;
    int          cycles = 0;
    strip_shadow shadow = new();

    led_strip_rainbow_controller_core #(
        .PIXEL_COUNT(PIXELS),
        .GROUP_SPAN(SPAN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .empty(empty),
        .pop(pop),
        .pixel(pixel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Cycle budget for the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= TIMEOUT_CYCLES)
        begin
            $display("led_strip_rainbow_controller_core test failed");
            $finish;
        end
    end

    // Result side: random stalls, or no pops at all while a hold-off runs.
    always @(posedge clk)
    begin
        if (holding)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99, 0) >= pop_stall_pct);
    end

    // Long hold-off of the result side, counted here.
    always
    begin
        @(start_hold);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // Every pixel word taken is checked against the oldest one expected.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            shadow.check_pixel(pixel);
    end

    function automatic cmd_t mk(logic [2:0] op, logic [4:0] pi, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
        cmd_t c;
        c.opcode = op;
        c.preset_index = pi;
        c.red_in = r;
        c.green_in = g;
        c.blue_in = b;
        return c;
    endfunction

    function automatic cmd_t any_cmd();
        return mk(3'($urandom_range(7, 0)), 5'($urandom_range(31, 0)),
                  8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                  8'($urandom_range(255, 0)));
    endfunction

    // Offer one command word, with random idle cycles ahead of it.
    task automatic send_cmd(cmd_t c);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        shadow.take_command(c);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow.write_reg(idx, data);
    endtask

    task automatic set_config(logic [15:0] delay, logic [6:0] cstep, logic [7:0] bstep);
        write_reg(CFG_STEP_DELAY, delay);
        write_reg(CFG_COLOR_STEP, {9'd0, cstep});
        write_reg(CFG_BRIGHT_STEP, {8'd0, bstep});
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected word, then let commands without output finish.
    task automatic settle();
        push <= 1'b0;
        while (shadow.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly paint, rainbow on and a run of ticks; the rest is raw noise.
    task automatic run_random(int n);
        int   sent;
        int   k;
        cmd_t c;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99, 0) < 70)
            begin
                c = any_cmd();
                if ($urandom_range(1, 0) == 1)
                    c.opcode = OP_SET;
                else
                begin
                    c.opcode = OP_PRESET;
                    c.preset_index = 5'($urandom_range(PRESET_COUNT - 1, 0));
                end
                send_cmd(c);
                c = any_cmd();
                c.opcode = OP_RAINBOW;
                send_cmd(c);
                k = $urandom_range(6, 1);
                repeat (k)
                begin
                    c = any_cmd();
                    c.opcode = ($urandom_range(9, 0) == 0) ? OP_SET : OP_TICK;
                    send_cmd(c);
                end
                sent += k + 2;
            end
            else
            begin
                c = any_cmd();
                send_cmd(c);
                if (!(c.opcode == OP_UNUSED ||
                      (c.opcode == OP_PRESET && c.preset_index >= PRESET_COUNT)))
                    sent++;
            end
        end
    endtask

    initial
    begin
        cmd_t c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset configuration: the countdown running out
        // without rainbow mode, a first rainbow step, color extremes, presets
        // in and past the table, brightness wrap and the unused opcode.
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_RAINBOW, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_SET, 5'd31, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(OP_SET, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_SET, 5'd10, 8'hA5, 8'h5A, 8'hC3));
        send_cmd(mk(OP_PRESET, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_PRESET, 5'd19, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_PRESET, 5'd20, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_PRESET, 5'd31, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(OP_BRIGHTER, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_DIMMER, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_UNUSED, 5'd0, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(OP_OFF, 5'd0, 8'h00, 8'h00, 8'h00));
        settle();

        // Zero step delay steps on every tick; set color keeps rainbow mode,
        // the brightness commands drop it.
        set_config(16'd0, 7'd64, 8'd255);
        send_cmd(mk(OP_PRESET, 5'd1, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_RAINBOW, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_SET, 5'd0, 8'h12, 8'h34, 8'h56));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_BRIGHTER, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_RAINBOW, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_DIMMER, 5'd0, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(OP_TICK, 5'd0, 8'h00, 8'h00, 8'h00));
        settle();

        // Random phases, each with its own idling pattern and configuration.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                    set_config(16'd1, 7'd1, 8'd1);
                end
                1:
                begin
                    send_idle_pct = 87;
                    pop_stall_pct = 0;
                    set_config(16'($urandom_range(4, 1)), 7'($urandom_range(64, 1)),
                               8'($urandom_range(255, 1)));
                end
                2:
                begin
                    send_idle_pct = 0;
                    pop_stall_pct = 87;
                    set_config(16'($urandom_range(4, 1)), 7'($urandom_range(64, 1)),
                               8'($urandom_range(255, 1)));
                end
                default:
                begin
                    send_idle_pct = 30;
                    pop_stall_pct = 30;
                    set_config(16'($urandom_range(3, 1)), 7'd64, 8'($urandom_range(255, 1)));
                end
            endcase
            run_random(35);
            settle();
        end

        // Hold off the result side while frame commands keep coming, so the
        // block fills up and pushes back on its input.
        send_idle_pct = 0;
        pop_stall_pct = 0;
        set_config(16'd65535, 7'($urandom_range(64, 1)), 8'($urandom_range(255, 1)));
        -> start_hold;
        repeat (10)
        begin
            c = any_cmd();
            case ($urandom_range(3, 0))
                0: c.opcode = OP_SET;
                1: c.opcode = OP_BRIGHTER;
                2: c.opcode = OP_DIMMER;
                default:
                begin
                    c.opcode = OP_PRESET;
                    c.preset_index = 5'($urandom_range(PRESET_COUNT - 1, 0));
                end
            endcase
            send_cmd(c);
        end
        settle();

        if (shadow.mismatches == 0 && shadow.pending_pixels.size() == 0)
            $display("led_strip_rainbow_controller_core test passed");
        else
            $display("led_strip_rainbow_controller_core test failed");
        $finish;
    end

endmodule
